[rtl/rocket_flight_phase_sequencer_top_macros.svh]
// Assertion macros for the flight phase sequencer.
// Used by the RTL file that carries concurrent checks (rfps_core); no other dependencies.
`ifndef ROCKET_FLIGHT_PHASE_SEQUENCER_TOP_MACROS_SVH
`define ROCKET_FLIGHT_PHASE_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define RFPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define RFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RFPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)

`define RFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/rfps_pkg.sv]
// Shared types and constants for the flight phase sequencer.
// Phase codes, register map, stream layout and the condition bundle; no dependencies.
`timescale 1ns / 1ps

package rfps_pkg;

  localparam int unsigned InWidth  = 176;
  localparam int unsigned OutWidth = 16;
  localparam int unsigned AddrWidth = 5;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_BOOST   = 3'd1;
  localparam logic [2:0] PH_COAST   = 3'd2;
  localparam logic [2:0] PH_DROGUE  = 3'd3;
  localparam logic [2:0] PH_MAIN    = 3'd4;
  localparam logic [2:0] PH_LANDING = 3'd5;
  localparam logic [2:0] PH_LANDED  = 3'd6;

  localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [2:0] REG_BOOST_LIM  = 3'd1;
  localparam logic [2:0] REG_COAST_LIM  = 3'd2;
  localparam logic [2:0] REG_DROGUE_LIM = 3'd3;
  localparam logic [2:0] REG_MAIN_LIM   = 3'd4;
  localparam logic [2:0] REG_LAND_TIME  = 3'd5;
  localparam logic [2:0] REG_LANDED_LIM = 3'd6;
  localparam logic [2:0] REG_PULSE      = 3'd7;

  localparam int signed VelLandingMin = -256;
  localparam int unsigned VelRestMax  = 128;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [22:0] boost_accel_limit;
    logic [22:0] coast_accel_limit;
    logic [22:0] drogue_speed_limit;
    logic [30:0] main_altitude_limit;
    logic [7:0]  landing_time_s;
    logic [22:0] landed_accel_limit;
    logic [15:0] pyro_len_ms;
  } cfg_t;

  typedef struct packed {
    logic c_boost;
    logic c_coast;
    logic c_drogue_spd;
    logic c_below_apo;
    logic c_vel_neg;
    logic c_below_main;
    logic c_landing;
    logic c_landed;
  } cond_t;

endpackage

[rtl/rocket_flight_phase_sequencer_top.sv]
// Top level of the flight phase sequencer: configuration port and stream datapath.
// Instantiates rfps_regs, rfps_pre and rfps_core; depends on rfps_pkg.
`timescale 1ns / 1ps

// One sensor word in, one status word out, at a sustained rate of one word per clock
// when out_tready is high. The input register evaluates every phase condition
// (including the 24x8 time-to-ground product), then the phase register, debounce
// timers and pyro pulse timers update and the status word is registered. The phase
// state is updated once per accepted word, so the rate is set by that single update
// loop. Both stages hold under back-pressure; write configuration only while no word
// is in flight.

module rocket_flight_phase_sequencer_top
  import rfps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // time_ms[31:0], vert_accel[55:32], vert_vel[79:56], altitude[111:80],
  // apogee_est[143:112], total_accel[167:144], pin_high[168], zero[175:169]
  input  logic [InWidth-1:0]   in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // phase[2:0], phase_changed[3], armed[4], drogue_pyro[5], main_pyro[6],
  // drogue_done[7], main_done[8], zero[15:9]
  output logic [OutWidth-1:0]  out_tdata,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [AddrWidth-1:0] cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  cfg_t        cfg;
  logic        pre_valid;
  logic        pre_take;
  logic [31:0] pre_time;
  logic        pre_pin;
  cond_t       pre_cond;

  assign cfg_pready = 1'b1;

  rfps_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  rfps_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .pre_valid (pre_valid),
    .pre_take  (pre_take),
    .pre_time  (pre_time),
    .pre_pin   (pre_pin),
    .pre_cond  (pre_cond)
  );

  rfps_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pre_valid (pre_valid),
    .pre_take  (pre_take),
    .pre_time  (pre_time),
    .pre_pin   (pre_pin),
    .pre_cond  (pre_cond),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

[rtl/rfps_regs.sv]
// APB-style configuration register file for the flight phase sequencer.
// Depends on rfps_pkg for the register map and the cfg_t bundle.
`timescale 1ns / 1ps

module rfps_regs
  import rfps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output cfg_t                 cfg
);

  cfg_t        cfg_r;
  logic        wr_en;
  logic [2:0]  idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[AddrWidth-1:2];
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms         <= 16'd150;
      cfg_r.boost_accel_limit   <= 23'd5023;
      cfg_r.coast_accel_limit   <= 23'd5023;
      cfg_r.drogue_speed_limit  <= 23'd128;
      cfg_r.main_altitude_limit <= 31'd115200;
      cfg_r.landing_time_s      <= 8'd10;
      cfg_r.landed_accel_limit  <= 23'd512;
      cfg_r.pyro_len_ms         <= 16'd500;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE:   cfg_r.debounce_ms         <= pwdata[15:0];
        REG_BOOST_LIM:  cfg_r.boost_accel_limit   <= pwdata[22:0];
        REG_COAST_LIM:  cfg_r.coast_accel_limit   <= pwdata[22:0];
        REG_DROGUE_LIM: cfg_r.drogue_speed_limit  <= pwdata[22:0];
        REG_MAIN_LIM:   cfg_r.main_altitude_limit <= pwdata[30:0];
        REG_LAND_TIME:  cfg_r.landing_time_s      <= pwdata[7:0];
        REG_LANDED_LIM: cfg_r.landed_accel_limit  <= pwdata[22:0];
        REG_PULSE:      cfg_r.pyro_len_ms         <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DEBOUNCE:   prdata = {16'd0, cfg_r.debounce_ms};
      REG_BOOST_LIM:  prdata = {9'd0, cfg_r.boost_accel_limit};
      REG_COAST_LIM:  prdata = {9'd0, cfg_r.coast_accel_limit};
      REG_DROGUE_LIM: prdata = {9'd0, cfg_r.drogue_speed_limit};
      REG_MAIN_LIM:   prdata = {1'b0, cfg_r.main_altitude_limit};
      REG_LAND_TIME:  prdata = {24'd0, cfg_r.landing_time_s};
      REG_LANDED_LIM: prdata = {9'd0, cfg_r.landed_accel_limit};
      REG_PULSE:      prdata = {16'd0, cfg_r.pyro_len_ms};
      default:        prdata = '0;
    endcase
  end

endmodule

[rtl/rfps_pre.sv]
// Input register stage: evaluates every phase condition of one sensor word.
// Depends on rfps_pkg for cfg_t, cond_t and the stream layout.
`timescale 1ns / 1ps

module rfps_pre
  import rfps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [InWidth-1:0]  in_data,
  output logic                pre_valid,
  input  logic                pre_take,
  output logic [31:0]         pre_time,
  output logic                pre_pin,
  output cond_t               pre_cond
);

  logic               valid_r;
  logic [31:0]        time_r;
  logic               pin_r;
  cond_t              cond_r;
  cond_t              cond_nxt;

  logic signed [23:0] acc;
  logic signed [23:0] vel;
  logic signed [31:0] alt;
  logic signed [31:0] apo;
  logic signed [23:0] tot;
  logic [23:0]        vel_mag;
  logic [23:0]        vel_neg_mag;
  logic [31:0]        land_prod;

  assign acc = in_data[55:32];
  assign vel = in_data[79:56];
  assign alt = in_data[111:80];
  assign apo = in_data[143:112];
  assign tot = in_data[167:144];

  assign vel_neg_mag = 24'(-vel);
  assign vel_mag     = vel[23] ? vel_neg_mag : vel;
  assign land_prod   = 32'(vel_neg_mag * cfg.landing_time_s);

  always_comb begin
    cond_nxt.c_boost      = ($signed({acc[23], acc}) > $signed({2'b00, cfg.boost_accel_limit}))
                            && !vel[23] && (vel != '0);
    cond_nxt.c_coast      = $signed({acc[23], acc}) < $signed({2'b00, cfg.coast_accel_limit});
    cond_nxt.c_drogue_spd = vel_mag < {1'b0, cfg.drogue_speed_limit};
    cond_nxt.c_below_apo  = alt < apo;
    cond_nxt.c_vel_neg    = vel[23];
    cond_nxt.c_below_main = $signed({alt[31], alt}) < $signed({2'b00, cfg.main_altitude_limit});
    cond_nxt.c_landing    = (vel < 24'(VelLandingMin))
                            && ($signed({alt[31], alt}) < $signed({1'b0, land_prod}));
    cond_nxt.c_landed     = (vel_mag < 24'(VelRestMax))
                            && ($signed({tot[23], tot}) < $signed({2'b00, cfg.landed_accel_limit}));
  end

  assign in_ready  = !valid_r || pre_take;
  assign pre_valid = valid_r;
  assign pre_time  = time_r;
  assign pre_pin   = pin_r;
  assign pre_cond  = cond_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      time_r <= in_data[31:0];
      pin_r  <= in_data[168];
      cond_r <= cond_nxt;
    end
  end

endmodule

[rtl/rfps_core.sv]
// Phase state machine, debounce timers, pyro pulses and the result register.
// Depends on rfps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "rocket_flight_phase_sequencer_top_macros.svh"

module rfps_core
  import rfps_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                pre_valid,
  output logic                pre_take,
  input  logic [31:0]         pre_time,
  input  logic                pre_pin,
  input  cond_t               pre_cond,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OutWidth-1:0] out_data
);

  logic [2:0]          phase_r, phase_nxt;
  logic                armed_r, armed_nxt;
  logic                dflag_r, dflag_nxt;
  logic                mflag_r, mflag_nxt;
  logic [31:0]         hold_r [6];
  logic [31:0]         hold_nxt;
  logic [31:0]         pstart_r [2];
  logic [1:0]          pact_r, pact_nxt;
  logic [1:0]          fire;
  logic                out_valid_r;
  logic [OutWidth-1:0] out_data_r;

  logic                load;
  logic                chk;
  logic                cond;
  logic                extra;
  logic                held;
  logic [31:0]         hold_cur;
  logic [31:0]         elapsed;

  assign load     = pre_valid && (!out_valid_r || out_ready);
  assign pre_take = load;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    chk   = 1'b0;
    cond  = 1'b0;
    extra = 1'b1;
    unique case (phase_r)
      PH_IDLE: begin
        chk  = 1'b1;
        cond = pre_cond.c_boost;
      end
      PH_BOOST: begin
        chk  = 1'b1;
        cond = pre_cond.c_coast;
      end
      PH_COAST: begin
        chk   = armed_r && !dflag_r;
        cond  = pre_cond.c_drogue_spd;
        extra = pre_cond.c_below_apo;
      end
      PH_DROGUE: begin
        chk   = armed_r && !mflag_r;
        cond  = pre_cond.c_vel_neg;
        extra = pre_cond.c_below_main;
      end
      PH_MAIN: begin
        chk  = 1'b1;
        cond = pre_cond.c_landing;
      end
      PH_LANDING: begin
        chk  = 1'b1;
        cond = pre_cond.c_landed;
      end
      default: begin
        chk = 1'b0;
      end
    endcase
  end

  assign hold_cur = (phase_r < PH_LANDED) ? hold_r[phase_r] : '0;
  assign elapsed  = pre_time - hold_cur;
  assign held     = cond && (hold_cur != '0) && (elapsed > {16'd0, cfg.debounce_ms});
  assign hold_nxt = !cond ? '0 : ((hold_cur == '0) ? pre_time : hold_cur);

  always_comb begin
    phase_nxt = phase_r;
    armed_nxt = armed_r;
    dflag_nxt = dflag_r;
    mflag_nxt = mflag_r;
    fire      = 2'b00;
    if (phase_r == PH_IDLE) begin
      armed_nxt = pre_pin;
    end
    if (chk && held && extra) begin
      phase_nxt = phase_r + 3'd1;
      if (phase_r == PH_COAST) begin
        dflag_nxt = 1'b1;
        fire[0]   = 1'b1;
      end
      if (phase_r == PH_DROGUE) begin
        mflag_nxt = 1'b1;
        fire[1]   = 1'b1;
      end
    end
    for (int ch = 0; ch < 2; ch++) begin
      pact_nxt[ch] = fire[ch] ||
                     (pact_r[ch] && ((pre_time - pstart_r[ch]) < {16'd0, cfg.pyro_len_ms}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      armed_r     <= 1'b0;
      dflag_r     <= 1'b0;
      mflag_r     <= 1'b0;
      pact_r      <= 2'b00;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        hold_r[i] <= '0;
      end
      for (int ch = 0; ch < 2; ch++) begin
        pstart_r[ch] <= '0;
      end
    end else begin
      if (load) begin
        phase_r <= phase_nxt;
        armed_r <= armed_nxt;
        dflag_r <= dflag_nxt;
        mflag_r <= mflag_nxt;
        pact_r  <= pact_nxt;
        if (chk && (phase_r < PH_LANDED)) begin
          hold_r[phase_r] <= hold_nxt;
        end
        for (int ch = 0; ch < 2; ch++) begin
          if (fire[ch]) begin
            pstart_r[ch] <= pre_time;
          end
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {7'd0, mflag_nxt, dflag_nxt, pact_nxt[1], pact_nxt[0], armed_nxt,
                     (phase_nxt != phase_r), phase_nxt};
    end
  end

  `RFPS_ASSERT_SAME(a_drogue_pulse_flag, clk, rst_n, pact_r[0], dflag_r, "drogue pulse without deploy")
  `RFPS_ASSERT_SAME(a_main_after_drogue, clk, rst_n, mflag_r, dflag_r, "main deployed before drogue")
  `RFPS_ASSERT_NEXT(a_phase_hold, clk, rst_n, !load, $stable(phase_r), "phase moved without a word")
  `RFPS_ASSERT_NEXT(a_armed_latched, clk, rst_n, load && (phase_r != PH_IDLE), $stable(armed_r), "armed changed in flight")

endmodule
